[hdl/totp_pkg.sv]
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types and constants for the time-based one-time code engine.
// ----------------------------------------------------------------------------
package totp_pkg;

    localparam int KEY_WORDS   = 8;
    localparam int KEY_IDX_W   = 3;
    localparam int TIME_W      = 63;
    localparam int CODE_W      = 20;
    localparam int CNT_W       = 7;

    // Step length and code modulus
    localparam logic [20:0] STEP_SECONDS = 21'd30;
    localparam logic [20:0] OTP_MODULUS  = 21'd1000000;

    // Reciprocals: ceil(2^26 / 30) is exact for 21-bit dividends,
    // ceil(2^51 / 10^6) is exact for 31-bit dividends
    localparam logic [21:0] DIV_RECIP = 22'd2236963;
    localparam logic [31:0] MOD_RECIP = 32'd2251799814;

    // SHA-1 chaining value and round constants
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0  = 32'h5A827999;
    localparam logic [31:0] K1  = 32'h6ED9EBA1;
    localparam logic [31:0] K2  = 32'h8F1BBCDC;
    localparam logic [31:0] K3  = 32'hCA62C1D6;

    // HMAC pads and message padding words
    localparam logic [31:0] IPAD_WORD   = 32'h36363636;
    localparam logic [31:0] OPAD_WORD   = 32'h5C5C5C5C;
    localparam logic [31:0] PAD_ONE     = 32'h80000000;
    localparam logic [31:0] LEN_INNER   = 32'd576;  // (64 + 8) bytes in bits
    localparam logic [31:0] LEN_OUTER   = 32'd672;  // (64 + 20) bytes in bits
    localparam logic [30:0] TRUNC_MASK  = 31'h7FFFFFFF;

    // Block codes within one HMAC
    localparam logic [1:0] BLK_IPAD  = 2'd0;
    localparam logic [1:0] BLK_MSG   = 2'd1;
    localparam logic [1:0] BLK_OPAD  = 2'd2;
    localparam logic [1:0] BLK_OUTER = 2'd3;

    // Which time step is being coded
    localparam logic [1:0] OTP_CUR  = 2'd0;
    localparam logic [1:0] OTP_PREV = 2'd1;
    localparam logic [1:0] OTP_NEXT = 2'd2;

    // Division: four 16-bit digits; modulo: multiply, then subtract
    localparam logic [6:0] LAST_DIV_STEP   = 7'd3;
    localparam logic [6:0] LAST_ROUND      = 7'd79;
    localparam logic [6:0] LAST_MOD_STEP   = 7'd1;

    typedef struct packed {
        logic             start;
        logic             div_step;
        logic             iv;
        logic             load;
        logic             round;
        logic             fin;
        logic             trunc;
        logic             mod_step;
        logic             record;
        logic             out_load;
        logic [CNT_W-1:0] round_idx;
        logic [1:0]       blk;
        logic [1:0]       sel;
    } totp_cmd_t;

    typedef struct packed {
        logic verify;
    } totp_sts_t;

endpackage

[hdl/totp_if.sv]
// ----------------------------------------------------------------------------
// totp channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface totp_req_if;
    import totp_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [TIME_W-1:0] unix_time;
    logic [CODE_W-1:0] candidate_code;
    modport source (output valid, func, unix_time, candidate_code, input ready);
    modport sink   (input valid, func, unix_time, candidate_code, output ready);
endinterface

interface totp_rsp_if;
    import totp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;
    logic              match;
    modport source (output valid, code, match, input ready);
    modport sink   (input valid, code, match, output ready);
endinterface

interface totp_cfg_if;
    import totp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KEY_IDX_W-1:0] index;
    logic [63:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/totp_ctrl.sv]
// ----------------------------------------------------------------------------
// totp_ctrl
// Sequencer: step division, four SHA-1 blocks per code, truncation, modulo.
// ----------------------------------------------------------------------------
module totp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  totp_pkg::totp_sts_t sts,
    output totp_pkg::totp_cmd_t cmd
);
    import totp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_BLK, S_ROUND, S_FIN, S_TRUNC, S_MOD, S_REC, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       blk_reg, blk_next;
    logic [1:0]       sel_reg, sel_next;
    logic             out_valid_reg, out_valid_next;
    logic             can_load;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign can_load  = !out_valid_reg || rsp_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        blk_next       = blk_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.round_idx  = cnt_reg;
        cmd.blk        = blk_reg;
        cmd.sel        = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_DIV_STEP)
                begin
                    blk_next   = BLK_IPAD;
                    sel_next   = OTP_CUR;
                    state_next = S_BLK;
                end
            end
            S_BLK:
            begin
                cmd.iv     = !blk_reg[0];
                cmd.load   = blk_reg[0];
                cnt_next   = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin  = 1'b1;
                blk_next = blk_reg + 1'b1;
                if (blk_reg == BLK_OUTER)
                    state_next = S_TRUNC;
                else
                    state_next = S_BLK;
            end
            S_TRUNC:
            begin
                cmd.trunc  = 1'b1;
                cnt_next   = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_MOD_STEP)
                    state_next = S_REC;
            end
            S_REC:
            begin
                cmd.record = 1'b1;
                blk_next   = BLK_IPAD;
                if (sts.verify && sel_reg != OTP_NEXT)
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_BLK;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            blk_reg       <= BLK_IPAD;
            sel_reg       <= OTP_CUR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            blk_reg       <= blk_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/totp_dp.sv]
// ----------------------------------------------------------------------------
// totp_dp
// Datapath: key registers, reciprocal divider, SHA-1 round unit, truncation,
// modulo by multiply then subtract, and result registers.
// ----------------------------------------------------------------------------
module totp_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [totp_pkg::KEY_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           in_func,
    input  logic [totp_pkg::TIME_W-1:0]    in_time,
    input  logic [totp_pkg::CODE_W-1:0]    in_cand,
    input  totp_pkg::totp_cmd_t            cmd,
    output totp_pkg::totp_sts_t            sts,
    output logic [totp_pkg::CODE_W-1:0]    out_code,
    output logic                           out_match
);
    import totp_pkg::*;

    logic [63:0]       key_reg [KEY_WORDS];
    logic              func_reg;
    logic [CODE_W-1:0] cand_reg;
    logic [63:0]       num_reg;
    logic [4:0]        rem30_reg;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]       h_reg [5];
    logic [31:0]       inner_reg [5];
    logic [31:0]       win_reg [16];
    logic [30:0]       mnum_reg;
    logic [62:0]       mprod_reg;
    logic [CODE_W-1:0] mrem_reg;
    logic [CODE_W-1:0] code_reg;
    logic              match_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_match_reg;

    logic [20:0]  div_v;
    logic [42:0]  div_prod;
    logic [15:0]  div_q;
    logic [20:0]  div_rem;
    logic [63:0]  ctr;
    logic [3:0]   widx;
    logic [63:0]  kword;
    logic [31:0]  khalf;
    logic [31:0]  blk_word;
    logic [31:0]  sched_word;
    logic [31:0]  w_cur;
    logic [31:0]  f_val;
    logic [31:0]  k_val;
    logic [31:0]  t_val;
    logic [159:0] mac;
    logic [7:0]   shamt;
    logic [159:0] mac_sh;
    logic [11:0]  mod_q;
    logic [30:0]  mod_qm;
    logic [30:0]  mod_diff;

    assign sts.verify = func_reg;
    assign out_code   = out_code_reg;
    assign out_match  = out_match_reg;

    // Division by the step length, one 16-bit digit per cycle by reciprocal
    assign div_v    = {rem30_reg, num_reg[63:48]};
    assign div_prod = {22'b0, div_v} * {21'b0, DIV_RECIP};
    assign div_q    = div_prod[41:26];
    assign div_rem  = div_v - {5'b0, div_q} * STEP_SECONDS;

    // Counter for the selected step; previous step of zero wraps to all ones
    always_comb
    begin
        case (cmd.sel)
            OTP_PREV: ctr = num_reg - 64'd1;
            OTP_NEXT: ctr = num_reg + 64'd1;
            default:  ctr = num_reg;
        endcase
    end

    // Message block word for rounds 0..15
    assign widx  = cmd.round_idx[3:0];
    assign kword = key_reg[widx[3:1]];
    assign khalf = widx[0] ? kword[31:0] : kword[63:32];
    always_comb
    begin
        blk_word = '0;
        case (cmd.blk)
            BLK_IPAD: blk_word = khalf ^ IPAD_WORD;
            BLK_OPAD: blk_word = khalf ^ OPAD_WORD;
            BLK_MSG:
            begin
                case (widx)
                    4'd0:    blk_word = ctr[63:32];
                    4'd1:    blk_word = ctr[31:0];
                    4'd2:    blk_word = PAD_ONE;
                    4'd15:   blk_word = LEN_INNER;
                    default: blk_word = '0;
                endcase
            end
            default:
            begin
                case (widx)
                    4'd0:    blk_word = inner_reg[0];
                    4'd1:    blk_word = inner_reg[1];
                    4'd2:    blk_word = inner_reg[2];
                    4'd3:    blk_word = inner_reg[3];
                    4'd4:    blk_word = inner_reg[4];
                    4'd5:    blk_word = PAD_ONE;
                    4'd15:   blk_word = LEN_OUTER;
                    default: blk_word = '0;
                endcase
            end
        endcase
    end

    // Message schedule from the 16-word window (win[15] is newest)
    assign sched_word = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_cur = (cmd.round_idx < 7'd16) ? blk_word
                                           : {sched_word[30:0], sched_word[31]};

    // Round function
    always_comb
    begin
        if (cmd.round_idx < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (cmd.round_idx < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (cmd.round_idx < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end
    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // Dynamic truncation: low nibble of the last byte picks four bytes
    assign mac    = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
    assign shamt  = 8'd128 - {1'b0, h_reg[4][3:0], 3'b000};
    assign mac_sh = mac >> shamt;

    // Modulo one million: quotient from the registered product, then subtract
    assign mod_q    = mprod_reg[62:51];
    assign mod_qm   = {19'b0, mod_q} * {10'b0, OTP_MODULUS};
    assign mod_diff = mnum_reg - mod_qm;

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_we)
            key_reg[cfg_index] <= cfg_data;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg  <= in_func;
            cand_reg  <= in_cand;
            num_reg   <= {1'b0, in_time};
            rem30_reg <= '0;
            match_reg <= 1'b0;
        end
        if (cmd.div_step)
        begin
            rem30_reg <= div_rem[4:0];
            num_reg   <= {num_reg[47:0], div_q};
        end
        if (cmd.iv)
        begin
            h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
            h_reg[3] <= IV3; h_reg[4] <= IV4;
            a_reg <= IV0; b_reg <= IV1; c_reg <= IV2; d_reg <= IV3; e_reg <= IV4;
        end
        if (cmd.load)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
        end
        if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_cur;
        end
        if (cmd.fin)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
            if (cmd.blk == BLK_MSG)
            begin
                inner_reg[0] <= h_reg[0] + a_reg;
                inner_reg[1] <= h_reg[1] + b_reg;
                inner_reg[2] <= h_reg[2] + c_reg;
                inner_reg[3] <= h_reg[3] + d_reg;
                inner_reg[4] <= h_reg[4] + e_reg;
            end
        end
        if (cmd.trunc)
            mnum_reg <= mac_sh[30:0] & TRUNC_MASK;
        if (cmd.mod_step)
        begin
            if (!cmd.round_idx[0])
                mprod_reg <= {32'b0, mnum_reg} * {31'b0, MOD_RECIP};
            else
                mrem_reg <= mod_diff[CODE_W-1:0];
        end
        if (cmd.record)
        begin
            if (cmd.sel == OTP_CUR)
                code_reg <= mrem_reg;
            if (func_reg && mrem_reg == cand_reg)
                match_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_code_reg  <= code_reg;
            out_match_reg <= match_reg;
        end
    end

endmodule

[hdl/hotp_totp_code_engine.sv]
// ----------------------------------------------------------------------------
// hotp_totp_code_engine
// Six-digit TOTP engine (HMAC-SHA1, 30 s step) with generate and verify.
// ----------------------------------------------------------------------------
// One request word is taken at a time. The step counter comes from a
// reciprocal divider that handles one 16-bit digit per cycle; each code
// then takes four SHA-1 compressions on a one-round-per-cycle unit, a
// truncation, a modulo by multiply then subtract, and a record step.
// Generate produces one code, verify three. The finished word waits in an
// output register, so the next request is accepted the cycle after the
// response is loaded, while that response is still pending. Key writes
// are always accepted and must only be issued while the engine is idle.
module hotp_totp_code_engine (
    input  logic       clk,
    input  logic       rst_n,
    totp_cfg_if.sink   cfg,
    totp_req_if.sink   req,
    totp_rsp_if.source rsp
);
    import totp_pkg::*;

    totp_cmd_t cmd;
    totp_sts_t sts;

    assign cfg.ready = 1'b1;

    totp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    totp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_func   (req.func),
        .in_time   (req.unix_time),
        .in_cand   (req.candidate_code),
        .cmd       (cmd),
        .sts       (sts),
        .out_code  (rsp.code),
        .out_match (rsp.match)
    );

endmodule

[hdl/totp_checker.sv]
// ----------------------------------------------------------------------------
// totp_checker
// Port-level checks on the code engine, bound to the top level.
// ----------------------------------------------------------------------------
module totp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_ready,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [totp_pkg::CODE_W-1:0] rsp_code,
    input logic                        rsp_match
);
    import totp_pkg::*;

    // Codes are always below one million
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp_code} < OTP_MODULUS))
        else $error("code out of range");

    // One request word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while busy");

    // Key writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("key write stalled");

    // Stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_code) && $stable(rsp_match)))
        else $error("response changed under stall");

endmodule

bind hotp_totp_code_engine totp_checker u_totp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg.ready),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_code  (rsp.code),
    .rsp_match (rsp.match)
);
